[src/fp8c_pkg.sv]
// fp8c_pkg: shared types, constants and a helper function for the fp8 codec
// no dependencies

package fp8c_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CODE_W = 8;

  typedef enum logic {
    MODE_DECODE = 1'b0,
    MODE_ENCODE = 1'b1
  } mode_t;

  typedef enum logic {
    FMT_E4M3 = 1'b0,
    FMT_E5M2 = 1'b1
  } fmt_t;

  localparam logic [31:0] E4M3_MAX_BITS = 32'h43E0_0000;
  localparam logic [31:0] E5M2_MAX_BITS = 32'h4760_0000;
  localparam logic [7:0] E4M3_NAN = 8'h7F;
  localparam logic [7:0] E5M2_NAN = 8'h7D;
  localparam logic [6:0] E4M3_SAT = 7'h7E;
  localparam logic [6:0] E5M2_SAT = 7'h7B;

  // stage 1 to stage 2 encode state
  typedef struct packed {
    logic       special;
    logic [7:0] special_code;
    logic       sign;
    logic [5:0] shift;
    logic [23:0] sig;
    logic [4:0] qbase;
    logic       fmt;
  } enc_s1_t;

  // stage 2 to stage 3 encode state
  typedef struct packed {
    logic       special;
    logic [7:0] special_code;
    logic       sign;
    logic [4:0] qbase;
    logic       fmt;
    logic [4:0] count;
    logic       round_up;
  } enc_s2_t;

  function automatic logic [31:0] decode_fp8(input logic [7:0] code, input logic fmt);
    logic [31:0] sign;
    logic [4:0]  e;
    logic [2:0]  m;
    logic [1:0]  b;
    logic [7:0]  ex;
    logic [22:0] frac;
    sign = {code[7], 31'd0};
    if (fmt == FMT_E5M2) begin
      e = code[6:2];
      m = {1'b0, code[1:0]};
    end else begin
      e = {1'b0, code[6:3]};
      m = code[2:0];
    end
    b = m[2] ? 2'd2 : (m[1] ? 2'd1 : 2'd0);
    decode_fp8 = sign;
    if (fmt == FMT_E4M3 && e == 5'd15 && m == 3'd7) begin
      decode_fp8 = sign | 32'h7FC0_0000;
    end else if (fmt == FMT_E5M2 && e == 5'd31) begin
      decode_fp8 = sign | ((m == 3'd0) ? 32'h7F80_0000 : 32'h7FC0_0000);
    end else if (e == 5'd0) begin
      if (m != 3'd0) begin
        ex = (fmt == FMT_E5M2) ? 8'd111 : 8'd118;
        ex = ex + {6'd0, b};
        frac = {20'd0, m - (3'd1 << b)} << (5'd23 - {3'd0, b});
        decode_fp8 = sign | {1'b0, ex, frac};
      end
    end else begin
      ex = (fmt == FMT_E5M2) ? 8'd112 : 8'd120;
      ex = ex + {3'd0, e};
      frac = (fmt == FMT_E5M2) ? {m[1:0], 21'd0} : {m, 20'd0};
      decode_fp8 = sign | {1'b0, ex, frac};
    end
  endfunction

endpackage

[src/fp8c_enc_front.sv]
// fp8c_enc_front: encode stage 1, special cases and rounding shift amount
// depends on fp8c_pkg

module fp8c_enc_front (
  input  logic [31:0]           value,
  input  logic                  fmt,
  output fp8c_pkg::enc_s1_t     s1
);
  import fp8c_pkg::*;

  logic [30:0] mag;
  logic [7:0]  ebits;
  logic [9:0]  qexp;
  logic [9:0]  minq;
  logic [9:0]  sh;

  always_comb begin
    mag = value[30:0];
    ebits = (mag[30:23] == 8'd0) ? 8'd1 : mag[30:23];
    minq = (fmt == FMT_E5M2) ? -10'sd16 : -10'sd9;
    qexp = {2'b00, ebits} - 10'd127 - ((fmt == FMT_E5M2) ? 10'd2 : 10'd3);
    if ($signed(qexp) < $signed(minq)) begin
      qexp = minq;
    end
    sh = qexp - ({2'b00, ebits} - 10'd150);
    s1.sign = value[31];
    s1.fmt = fmt;
    s1.sig = {(mag[30:23] != 8'd0), mag[22:0]};
    s1.shift = (sh > 10'd31) ? 6'd32 : sh[5:0];
    s1.qbase = 5'(qexp - minq);
    s1.special = 1'b1;
    s1.special_code = {value[31], 7'd0};
    if ({1'b0, mag} > 32'h7F80_0000) begin
      s1.special_code = (fmt == FMT_E5M2) ? E5M2_NAN : E4M3_NAN;
    end else if (mag == 31'd0) begin
      s1.special_code = {value[31], 7'd0};
    end else if ({1'b0, mag} >= ((fmt == FMT_E5M2) ? E5M2_MAX_BITS : E4M3_MAX_BITS)) begin
      s1.special_code = {value[31], (fmt == FMT_E5M2) ? E5M2_SAT : E4M3_SAT};
    end else begin
      s1.special = 1'b0;
    end
  end

endmodule

[src/fp8c_enc_round.sv]
// fp8c_enc_round: encode stage 2, significand shift and round decision
// depends on fp8c_pkg

module fp8c_enc_round (
  input  fp8c_pkg::enc_s1_t s1,
  output fp8c_pkg::enc_s2_t s2
);
  import fp8c_pkg::*;

  logic [55:0] wide;
  logic [23:0] cnt;
  logic [31:0] rem;
  logic [31:0] half;

  always_comb begin
    wide = {s1.sig, 32'd0} >> s1.shift;
    cnt = wide[55:32];
    rem = wide[31:0];
    half = 32'h8000_0000;
    s2.special = s1.special;
    s2.special_code = s1.special_code;
    s2.sign = s1.sign;
    s2.qbase = s1.qbase;
    s2.fmt = s1.fmt;
    s2.count = cnt[4:0];
    s2.round_up = (rem > half) || (rem == half && cnt[0]);
  end

endmodule

[src/fp8_codec.sv]
// fp8_codec: fp32 <-> fp8 (E4M3FN / E5M2) converter, top level
// an accepted input item passes through the stage 1, stage 2 and output registers to the result item
// throughput one item per cycle while out_stall is low, through a three-stage pipeline
// stall freezes every occupied stage whose successor cannot advance, nothing lost
// rst_n synchronous active low clears valid bits and the format register
// depends on fp8c_pkg, fp8c_enc_front, fp8c_enc_round

module fp8_codec (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_fp8_format_we,
  input  logic        cfg_fp8_format,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_value_in,
  input  logic [7:0]  in_code_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_code_out,
  output logic [31:0] out_value_out
);
  import fp8c_pkg::*;

  logic fmt_r;
  logic v1_r, v2_r, v3_r;
  logic m1_r, m2_r;
  logic [31:0] dec1_r, dec2_r;
  enc_s1_t s1_nxt, s1_r;
  enc_s2_t s2_nxt, s2_r;
  logic [7:0]  code_r;
  logic [31:0] value_r;
  logic adv3, adv2, adv1;
  logic [7:0] code_nxt;

  assign adv3 = !v3_r || !out_stall;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;

  fp8c_enc_front u_front (.value(in_value_in), .fmt(fmt_r), .s1(s1_nxt));
  fp8c_enc_round u_round (.s1(s1_r), .s2(s2_nxt));

  always_comb begin
    code_nxt = {s2_r.sign, 7'(({2'b00, s2_r.qbase} << (s2_r.fmt ? 2 : 3))
      + {2'b00, s2_r.count} + {6'd0, s2_r.round_up})};
    if (s2_r.special) begin
      code_nxt = s2_r.special_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (cfg_fp8_format_we) begin
        fmt_r <= cfg_fp8_format;
      end
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      m1_r <= in_mode;
      s1_r <= s1_nxt;
      dec1_r <= decode_fp8(in_code_in, fmt_r);
    end
    if (adv2) begin
      m2_r <= m1_r;
      s2_r <= s2_nxt;
      dec2_r <= dec1_r;
    end
    if (adv3) begin
      code_r <= (m2_r == MODE_ENCODE) ? code_nxt : 8'd0;
      value_r <= (m2_r == MODE_ENCODE) ? 32'd0 : dec2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_code_out = code_r;
  assign out_value_out = value_r;

endmodule

[sim/fp8_codec_tb.sv]
// fp8_codec_tb: self-checking testbench for the fp32 <-> fp8 converter
// predicts every result with its own conversion functions and a scoreboard class
// depends on fp8c_pkg and fp8_codec

module fp8_codec_tb;
  import fp8c_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  code;
    logic [31:0] value;
  } fp8_result_t;

  function automatic logic [31:0] expand_fp8(logic [7:0] code, fmt_t fmt);
    logic [31:0] sgn;
    int unsigned mbits, bias, ex, man, lead;
    sgn = {code[7], 31'd0};
    mbits = (fmt == FMT_E5M2) ? 2 : 3;
    bias = (fmt == FMT_E5M2) ? 15 : 7;
    ex = 32'(code[6:0]) >> mbits;
    man = 32'(code[6:0]) & ((1 << mbits) - 1);
    if (fmt == FMT_E4M3 && ex == 15 && man == 7) return sgn | 32'h7FC0_0000;
    if (fmt == FMT_E5M2 && ex == 31)
      return sgn | ((man == 0) ? 32'h7F80_0000 : 32'h7FC0_0000);
    if (ex == 0) begin
      if (man == 0) return sgn;
      lead = man[2] ? 2 : (man[1] ? 1 : 0);
      return sgn | ((128 - bias - mbits + lead) << 23) | ((man - (1 << lead)) << (23 - lead));
    end
    return sgn | ((ex + 127 - bias) << 23) | (man << (23 - mbits));
  endfunction

  function automatic logic [7:0] round_to_fp8(logic [31:0] v, fmt_t fmt);
    logic [7:0] sgn;
    logic [30:0] mag;
    int mbits, minq, ebits, qexp, sh;
    longint unsigned sig, cnt, rem, half;
    sgn = {v[31], 7'd0};
    mag = v[30:0];
    mbits = (fmt == FMT_E5M2) ? 2 : 3;
    minq = (fmt == FMT_E5M2) ? -16 : -9;
    if (mag > 31'h7F80_0000) return (fmt == FMT_E5M2) ? E5M2_NAN : E4M3_NAN;
    if (mag == 0) return sgn;
    if ({1'b0, mag} >= ((fmt == FMT_E5M2) ? E5M2_MAX_BITS : E4M3_MAX_BITS))
      return sgn | {1'b0, (fmt == FMT_E5M2) ? E5M2_SAT : E4M3_SAT};
    ebits = 32'(mag[30:23]);
    sig = 64'(mag[22:0]);
    if (ebits == 0) ebits = 1;
    else sig = sig | 64'h80_0000;
    qexp = ebits - 127 - mbits;
    if (qexp < minq) qexp = minq;
    sh = qexp - (ebits - 150);
    if (sh > 31) cnt = 0;
    else begin
      cnt = sig >> sh;
      rem = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && cnt[0])) cnt++;
    end
    return sgn | 8'((longint'(qexp - minq) << mbits) + cnt);
  endfunction

  class fp8_scoreboard;
    fp8_result_t pending[$];
    fmt_t fmt;
    int errors;

    function new();
      fmt = FMT_E4M3;
      errors = 0;
    endfunction

    function void note_item(mode_t mode, logic [31:0] value, logic [7:0] code);
      fp8_result_t r;
      if (mode == MODE_ENCODE) begin
        r.code = round_to_fp8(value, fmt);
        r.value = '0;
      end else begin
        r.code = '0;
        r.value = expand_fp8(code, fmt);
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [7:0] code, logic [31:0] value);
      fp8_result_t r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item code %h value %h", code, value);
        return;
      end
      r = pending.pop_front();
      if (code !== r.code || value !== r.value) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected code %h value %h, got code %h value %h",
                   r.code, r.value, code, value);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_fp8_format_we, cfg_fp8_format;
  logic in_valid, in_stall, in_mode;
  logic [31:0] in_value_in;
  logic [7:0] in_code_in;
  logic out_valid, out_stall;
  logic [7:0] out_code_out;
  logic [31:0] out_value_out;

  fp8_scoreboard sb;
  int idle_cycles;
  bit hold_off, stim_done;

  fp8_codec dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_fp8_format_we(cfg_fp8_format_we), .cfg_fp8_format(cfg_fp8_format),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_value_in(in_value_in), .in_code_in(in_code_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code_out(out_code_out), .out_value_out(out_value_out)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_item(mode_t'(in_mode), in_value_in, in_code_in);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_code_out, out_value_out);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)
        || (sb.pending.size() == 0 && !in_valid)))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("fp8_codec_tb: errors");
      $finish;
    end
  end

  // receiver: random stalls, with long stalls when asked
  initial begin
    int g;
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    while (1) begin
      if (hold_off) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end else begin
        g = (stim_done || $urandom_range(3) == 0) ? 0 : gap_len();
        if (g > 0) begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(mode_t mode, logic [31:0] value, logic [7:0] code, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_value_in <= value;
    in_code_in <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_format(fmt_t f);
    cfg_fp8_format_we <= 1'b1;
    cfg_fp8_format <= f;
    @(posedge clk);
    cfg_fp8_format_we <= 1'b0;
    sb.fmt = f;
  endtask

  function automatic logic [31:0] rand_fp32(fmt_t f);
    int p;
    logic [31:0] v;
    p = $urandom_range(99);
    v = $urandom;
    if (p < 60)
      v[30:23] = (f == FMT_E5M2) ? 8'($urandom_range(148, 100)) : 8'($urandom_range(136, 112));
    else if (p < 70) v[22:0] = {v[22:20], 20'h80000};
    else if (p < 78) v[30:23] = 8'hFF;
    else if (p < 85) v[30:23] = 8'h00;
    return v;
  endfunction

  task automatic run_random(int n, bit gaps);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1)) send_item(MODE_ENCODE, rand_fp32(sb.fmt), 8'($urandom), gaps);
      else send_item(MODE_DECODE, $urandom, 8'($urandom), gaps);
    end
  endtask

  initial begin
    logic [31:0] dir_vals[14];
    sb = new();
    idle_cycles = 0;
    hold_off = 0;
    stim_done = 0;
    rst_n = 0;
    cfg_fp8_format_we = 0;
    cfg_fp8_format = 0;
    in_valid = 0;
    in_mode = 0;
    in_value_in = 0;
    in_code_in = 0;
    dir_vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h43E0_0000, 32'hC3DF_FFFF,
                 32'h4760_0000, 32'h0000_0001, 32'h3B00_0000, 32'h3780_0000,
                 32'h3F88_0000, 32'h3F98_0000};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int f = 0; f < 2; f++) begin
      set_format(fmt_t'(f));
      foreach (dir_vals[i]) send_item(MODE_ENCODE, dir_vals[i], 8'h00, 0);
      foreach (dir_vals[i]) send_item(MODE_DECODE, 32'h0, 8'(i * 19 + 3), 0);
      send_item(MODE_DECODE, 32'h0, 8'h7F, 0);
      send_item(MODE_DECODE, 32'h0, 8'hFC, 0);
      send_item(MODE_DECODE, 32'h0, 8'h80, 0);
      drain();
    end
    for (int ph = 0; ph < 4; ph++) begin
      set_format(fmt_t'(ph % 2));
      if (ph == 1) begin
        hold_off = 1;
        fork
          begin
            repeat (60) @(posedge clk);
            hold_off = 0;
          end
          run_random(20, 0);
        join
      end
      run_random(80, 1);
      run_random(80, 0);
      drain();
    end
    stim_done = 1;
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("fp8_codec_tb: clean");
    else $display("fp8_codec_tb: errors");
    $finish;
  end
endmodule

[files.f]
src/fp8c_pkg.sv
src/fp8c_enc_front.sv
src/fp8c_enc_round.sv
src/fp8_codec.sv
sim/fp8_codec_tb.sv
